// ===== hdl/gcg_pkg.sv =====
`default_nettype none
package gcg_pkg;

  localparam int CHAR_COUNT   = 8;
  localparam int SINE_ENTRIES = 256;
  localparam int PHASE_BITS   = 16;

  localparam int SINE_BITS = $clog2(SINE_ENTRIES);
  localparam int CI_W      = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;

  typedef longint unsigned u64_t;

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned HUE_OFF16 = 4589;
  localparam int unsigned VAL_OFF16 = 2608;
  localparam int unsigned SAT_OFF16 = 2086;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic signed [15:0] sine_t;
  typedef sine_t sine_tab_t [SINE_ENTRIES];
  typedef phase_t off_arr_t [CHAR_COUNT];

  localparam phase_t QUARTER_TURN = phase_t'(1) << (PHASE_BITS - 2);

  // Configuration register indexes.
  localparam logic [1:0] CFG_PHASE_STEP  = 2'd0;
  localparam logic [1:0] CFG_CHAR_ENABLE = 2'd1;
  localparam logic [1:0] CFG_LED_ENABLE  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_LED    = 2'd1;
  localparam logic [1:0] KIND_DIRECT = 2'd2;

  // Input operations.
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_DIRECT = 1'b1;

  // First-quadrant sine in Q30 by a Taylor series to x^13, rounded to Q14.
  function automatic sine_t quarter_sin(u64_t x);
    u64_t x2;
    u64_t term;
    longint sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    return sine_t'((u64_t'(sum) + 64'd32768) >> 16);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    int unsigned a4;
    int unsigned quad;
    int unsigned rem;
    int unsigned r;
    sine_t v;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      a4 = 4 * k;
      quad = a4 / SINE_ENTRIES;
      rem = a4 % SINE_ENTRIES;
      r = quad[0] ? (SINE_ENTRIES - rem) : rem;
      v = quarter_sin((u64_t'(r) * HALF_PI_Q30) / SINE_ENTRIES);
      tab[k] = (quad >= 2) ? -v : v;
    end
    return tab;
  endfunction

  function automatic off_arr_t build_offsets(int unsigned per16);
    off_arr_t offs;
    u64_t prod;
    for (int i = 0; i < CHAR_COUNT; i++) begin
      prod = ((u64_t'(per16) * u64_t'(i)) << PHASE_BITS) >> 16;
      offs[i] = phase_t'(prod);
    end
    return offs;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();
  localparam off_arr_t  HUE_OFF  = build_offsets(HUE_OFF16);
  localparam off_arr_t  VAL_OFF  = build_offsets(VAL_OFF16);
  localparam off_arr_t  SAT_OFF  = build_offsets(SAT_OFF16);

endpackage
`default_nettype wire

// ===== hdl/glow_color_generator_top.sv =====
// Direct conversion: an 8-step modulo-360 reduction, then up to 5 hue-region
// subtractions and 5 multiplies.
// Animation tick: up to 9 colors per tick,
// all on one shared 17x10 multiplier; a new item is taken once the last color is held.
// Reset (rst_n low, synchronous) zeroes the phase, loads phase_step 365 and
// sets both enables; there is no clearing pass.
`default_nettype none
module glow_color_generator_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_op,
  input  wire  signed [15:0]     in_hue,
  input  wire         [7:0]      in_sat,
  input  wire         [7:0]      in_val,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic        [1:0]      out_kind,
  output logic        [2:0]      out_index,
  output logic        [7:0]      out_red,
  output logic        [7:0]      out_green,
  output logic        [7:0]      out_blue,
  output logic                   out_last,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire         [1:0]      cfg_index,
  input  wire         [15:0]     cfg_data
);
  import gcg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HMOD, S_HUE_SIN, S_HUE_MUL, S_VAL_SIN, S_VAL_MUL, S_SAT_SIN,
    S_SAT_MUL, S_SAT_FIN, S_REGION, S_M1, S_M2, S_M3, S_M4, S_M5, S_OUT
  } state_t;

  state_t            state_r;
  logic [15:0]       phase_step_r;
  logic              char_en_r;
  logic              led_en_r;
  phase_t            phase_r;
  phase_t            p15_r;
  logic [CI_W-1:0]   ci_r;
  logic              led_r;
  logic              direct_r;
  logic [2:0]        k_r;
  logic [16:0]       h_r;
  logic [2:0]        region_r;
  logic [7:0]        rem_r;
  logic [7:0]        s_r;
  logic [7:0]        v_r;
  logic [7:0]        m1_r;
  logic [7:0]        m2_r;
  logic [7:0]        p_r;
  logic [7:0]        q_r;
  sine_t             sine_r;
  logic signed [26:0] prod_r;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [2:0]        out_index_r;
  logic [7:0]        out_red_r;
  logic [7:0]        out_green_r;
  logic [7:0]        out_blue_r;
  logic              out_last_r;

  phase_t            phase_nxt;
  logic [PHASE_BITS+1:0] p3;
  phase_t            hue_ang;
  phase_t            val_ang;
  phase_t            sat_ang;
  logic              mul_en;
  logic signed [16:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [26:0] mul_p;
  logic signed [27:0] hq;
  logic signed [27:0] hdiv;
  logic [7:0]        hue_w;
  logic signed [26:0] tq;
  logic signed [26:0] vraw;
  logic signed [26:0] sraw;
  logic [7:0]        v_clamped;
  logic [7:0]        s_clamped;
  logic [16:0]       mod_sub;
  logic [9:0]        rem17;
  logic [7:0]        t_w;
  logic [7:0]        r_w;
  logic [7:0]        g_w;
  logic [7:0]        b_w;
  logic              more_w;
  logic [17:0]       hsum;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_index = out_index_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_last  = out_last_r;

  always_comb begin
    phase_nxt = phase_r + phase_t'(phase_step_r);
    p3 = {2'b00, phase_nxt} + {1'b0, phase_nxt, 1'b0};
    hue_ang = phase_r + (led_r ? phase_t'(0) : HUE_OFF[ci_r]);
    val_ang = p15_r + (led_r ? phase_t'(0) : VAL_OFF[ci_r]);
    sat_ang = phase_r + SAT_OFF[ci_r] + QUARTER_TURN;
    hsum = 18'($signed(in_hue)) + 18'sd36000;
  end

  // Shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_HUE_MUL: begin
        mul_a = 17'(sine_r);
        mul_b = 10'sd17;
      end
      S_VAL_MUL: begin
        mul_a = 17'(sine_r);
        mul_b = led_r ? 10'sd35 : 10'sd30;
      end
      S_SAT_MUL: begin
        mul_a = 17'(sine_r);
        mul_b = 10'sd10;
      end
      S_M1: begin
        mul_a = $signed({9'd0, s_r});
        mul_b = $signed({2'b00, rem_r});
      end
      S_M2: begin
        mul_a = $signed({9'd0, s_r});
        mul_b = $signed({2'b00, 8'd255 - rem_r});
      end
      S_M3: begin
        mul_a = $signed({9'd0, v_r});
        mul_b = $signed({2'b00, 8'd255 - s_r});
      end
      S_M4: begin
        mul_a = $signed({9'd0, v_r});
        mul_b = $signed({2'b00, 8'd255 - m1_r});
      end
      S_M5: begin
        mul_a = $signed({9'd0, v_r});
        mul_b = $signed({2'b00, 8'd255 - m2_r});
      end
      default: mul_en = 1'b0;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Glow value shaping from the previous product.
  always_comb begin
    hq = 28'sd286720 + 28'(prod_r);
    hdiv = hq >>> 14;
    if (hq < 0) begin
      hue_w = 8'd0;
    end else if (hdiv > 28'sd40) begin
      hue_w = 8'd40;
    end else begin
      hue_w = hdiv[7:0];
    end
    tq = (prod_r < 0) ? ((prod_r + 27'sd16383) >>> 14) : (prod_r >>> 14);
    vraw = (led_r ? 27'sd220 : 27'sd225) + tq;
    sraw = 27'sd245 + tq;
    if (led_r && vraw < 27'sd140) begin
      v_clamped = 8'd140;
    end else if (!led_r && vraw < 27'sd180) begin
      v_clamped = 8'd180;
    end else if (vraw > 27'sd255) begin
      v_clamped = 8'd255;
    end else begin
      v_clamped = vraw[7:0];
    end
    if (sraw < 27'sd220) begin
      s_clamped = 8'd220;
    end else if (sraw > 27'sd255) begin
      s_clamped = 8'd255;
    end else begin
      s_clamped = sraw[7:0];
    end
  end

  // Hue reduction and final color selection.
  always_comb begin
    mod_sub = 17'd360 << k_r;
    rem17 = ({4'd0, h_r[5:0]} << 4) + {4'd0, h_r[5:0]};
    t_w = prod_r[15:8];
    unique case (region_r)
      3'd0: begin
        r_w = v_r; g_w = t_w; b_w = p_r;
      end
      3'd1: begin
        r_w = q_r; g_w = v_r; b_w = p_r;
      end
      3'd2: begin
        r_w = p_r; g_w = v_r; b_w = t_w;
      end
      3'd3: begin
        r_w = p_r; g_w = q_r; b_w = v_r;
      end
      3'd4: begin
        r_w = t_w; g_w = p_r; b_w = v_r;
      end
      default: begin
        r_w = v_r; g_w = p_r; b_w = q_r;
      end
    endcase
    if (s_r == 8'd0) begin
      r_w = v_r; g_w = v_r; b_w = v_r;
    end
    more_w = !direct_r && !led_r && ((ci_r != CI_W'(CHAR_COUNT - 1)) || led_en_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_step_r <= 16'd365;
      char_en_r    <= 1'b1;
      led_en_r     <= 1'b1;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
      ci_r         <= '0;
      led_r        <= 1'b0;
      direct_r     <= 1'b0;
      k_r          <= '0;
      region_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PHASE_STEP:  phase_step_r <= cfg_data;
          CFG_CHAR_ENABLE: char_en_r <= cfg_data[0];
          CFG_LED_ENABLE:  led_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (mul_en) begin
        prod_r <= mul_p;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_op == OP_DIRECT) begin
              direct_r <= 1'b1;
              led_r    <= 1'b0;
              ci_r     <= '0;
              h_r      <= hsum[16:0];
              s_r      <= in_sat;
              v_r      <= in_val;
              k_r      <= 3'd7;
              state_r  <= S_HMOD;
            end else begin
              direct_r <= 1'b0;
              phase_r  <= phase_nxt;
              p15_r    <= p3[PHASE_BITS:1];
              ci_r     <= '0;
              if (char_en_r) begin
                led_r   <= 1'b0;
                state_r <= S_HUE_SIN;
              end else if (led_en_r) begin
                led_r   <= 1'b1;
                state_r <= S_HUE_SIN;
              end
            end
          end
        end
        S_HMOD: begin
          if (h_r >= mod_sub) begin
            h_r <= h_r - mod_sub;
          end
          k_r <= k_r - 3'd1;
          if (k_r == 3'd0) begin
            region_r <= '0;
            state_r  <= S_REGION;
          end
        end
        S_HUE_SIN: begin
          sine_r  <= SINE_TAB[hue_ang[PHASE_BITS-1 -: SINE_BITS]];
          state_r <= S_HUE_MUL;
        end
        S_HUE_MUL: state_r <= S_VAL_SIN;
        S_VAL_SIN: begin
          h_r     <= {9'd0, hue_w};
          sine_r  <= SINE_TAB[val_ang[PHASE_BITS-1 -: SINE_BITS]];
          state_r <= S_VAL_MUL;
        end
        S_VAL_MUL: state_r <= S_SAT_SIN;
        S_SAT_SIN: begin
          v_r     <= v_clamped;
          sine_r  <= SINE_TAB[sat_ang[PHASE_BITS-1 -: SINE_BITS]];
          state_r <= S_SAT_MUL;
        end
        S_SAT_MUL: state_r <= S_SAT_FIN;
        S_SAT_FIN: begin
          s_r      <= led_r ? 8'd250 : s_clamped;
          region_r <= '0;
          state_r  <= S_REGION;
        end
        S_REGION: begin
          if (h_r >= 17'd60) begin
            h_r      <= h_r - 17'd60;
            region_r <= region_r + 3'd1;
          end else begin
            rem_r   <= rem17[9:2];
            state_r <= S_M1;
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          m1_r    <= prod_r[15:8];
          state_r <= S_M3;
        end
        S_M3: begin
          m2_r    <= prod_r[15:8];
          state_r <= S_M4;
        end
        S_M4: begin
          p_r     <= prod_r[15:8];
          state_r <= S_M5;
        end
        S_M5: begin
          q_r     <= prod_r[15:8];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= direct_r ? KIND_DIRECT : (led_r ? KIND_LED : KIND_CHAR);
            out_index_r <= (direct_r || led_r) ? 3'd0 : 3'(ci_r);
            out_red_r   <= r_w;
            out_green_r <= g_w;
            out_blue_r  <= b_w;
            out_last_r  <= !more_w;
            if (!more_w) begin
              state_r <= S_IDLE;
            end else if (ci_r != CI_W'(CHAR_COUNT - 1)) begin
              ci_r    <= ci_r + CI_W'(1);
              state_r <= S_HUE_SIN;
            end else begin
              led_r   <= 1'b1;
              state_r <= S_HUE_SIN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gcg_checker.sv =====
`default_nettype none
module gcg_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input wire                in_op,
  input wire                out_valid,
  input wire                out_ready,
  input wire [1:0]          out_kind,
  input wire [2:0]          out_index,
  input wire [7:0]          out_red,
  input wire [7:0]          out_green,
  input wire [7:0]          out_blue,
  input wire                out_last
);
  import gcg_pkg::*;

  // A held item keeps its color until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_last))
    else $error("held result changed");

  // A direct conversion keeps the block busy for the cycle after it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_DIRECT |=> !in_ready)
    else $error("ready during direct conversion");

  // Only character colors carry a nonzero position.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CHAR |-> out_index == 3'd0)
    else $error("index on non-character item");

  // A direct conversion and the LED color always close their input.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DIRECT || out_kind == KIND_LED) |-> out_last)
    else $error("last missing");

endmodule

bind glow_color_generator_top gcg_checker u_gcg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_kind  (out_kind),
  .out_index (out_index),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_last  (out_last)
);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import gcg_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 140;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic last;
  } color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_TICK;
  logic signed [15:0] in_hue = '0;
  logic [7:0] in_sat = '0;
  logic [7:0] in_val = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [2:0] out_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_PHASE_STEP;
  logic [15:0] cfg_data = '0;

  int wave_lut [SINE_ENTRIES];
  phase_t model_phase;
  logic [15:0] model_step;
  logic model_char_en;
  logic model_led_en;
  color_t expected_colors[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit idling_on = 1'b1;

  glow_color_generator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_hue(in_hue),
    .in_sat(in_sat),
    .in_val(in_val),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_index(out_index),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int taylor_q14(u64_t x);
    u64_t x2;
    u64_t term;
    longint acc;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'((u64_t'(acc) + 64'd32768) >> 16);
  endfunction

  function automatic void build_wave_lut();
    int unsigned quad;
    int unsigned rem;
    int unsigned r;
    int v;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      quad = (4 * k) / SINE_ENTRIES;
      rem = (4 * k) % SINE_ENTRIES;
      r = (quad % 2 == 1) ? (SINE_ENTRIES - rem) : rem;
      v = taylor_q14((u64_t'(r) * HALF_PI_Q30) / SINE_ENTRIES);
      wave_lut[k] = (quad >= 2) ? -v : v;
    end
  endfunction

  function automatic int sine_of(phase_t a);
    return wave_lut[(int'(a) * SINE_ENTRIES) >> PHASE_BITS];
  endfunction

  function automatic int fit(int x, int lo, int hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic int glow_hue_of(phase_t a);
    int hq;
    hq = 286720 + 17 * sine_of(a);
    if (hq < 0) begin
      hq = 0;
    end
    return fit(hq / 16384, 0, 40);
  endfunction

  function automatic logic [23:0] hsv_to_rgb(int h, int s, int v);
    int region;
    int frac;
    int p;
    int q;
    int t;
    int r;
    int g;
    int b;
    if (s == 0) begin
      return {3{v[7:0]}};
    end
    h = h % 360;
    if (h < 0) begin
      h = h + 360;
    end
    region = h / 60;
    frac = ((h % 60) * 255) / 60;
    p = (v * (255 - s)) >> 8;
    q = (v * (255 - ((s * frac) >> 8))) >> 8;
    t = (v * (255 - ((s * (255 - frac)) >> 8))) >> 8;
    case (region)
      0: begin r = v; g = t; b = p; end
      1: begin r = q; g = v; b = p; end
      2: begin r = p; g = v; b = t; end
      3: begin r = p; g = q; b = v; end
      4: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic void predict_colors(logic op, logic signed [15:0] hue, logic [7:0] sat,
                                         logic [7:0] val);
    color_t c;
    color_t batch[$];
    phase_t p;
    phase_t p15;
    int hv;
    int vv;
    int sv;
    if (op == OP_DIRECT) begin
      c.kind = KIND_DIRECT;
      c.index = '0;
      {c.red, c.green, c.blue} = hsv_to_rgb(hue, sat, val);
      c.last = 1'b1;
      expected_colors.push_back(c);
      return;
    end
    model_phase = model_phase + model_step;
    p = model_phase;
    p15 = phase_t'((3 * int'(p)) >> 1);
    if (model_char_en) begin
      for (int i = 0; i < CHAR_COUNT; i++) begin
        hv = glow_hue_of(p + phase_t'(HUE_OFF16 * i));
        vv = 225 + (30 * sine_of(p15 + phase_t'(VAL_OFF16 * i))) / 16384;
        sv = 245 + (10 * sine_of(p + phase_t'(SAT_OFF16 * i) + QUARTER_TURN)) / 16384;
        c.kind = KIND_CHAR;
        c.index = i[2:0];
        {c.red, c.green, c.blue} = hsv_to_rgb(hv, fit(sv, 220, 255), fit(vv, 180, 255));
        c.last = 1'b0;
        batch.push_back(c);
      end
    end
    if (model_led_en) begin
      vv = 220 + (35 * sine_of(p15)) / 16384;
      c.kind = KIND_LED;
      c.index = '0;
      {c.red, c.green, c.blue} = hsv_to_rgb(glow_hue_of(p), 250, fit(vv, 140, 255));
      c.last = 1'b0;
      batch.push_back(c);
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[k]) begin
      expected_colors.push_back(batch[k]);
    end
  endfunction

  task automatic send_item(input logic op, input logic signed [15:0] hue, input logic [7:0] sat,
                           input logic [7:0] val);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_hue <= hue;
    in_sat <= sat;
    in_val <= val;
    do @(negedge clk); while (!in_ready);
    predict_colors(op, hue, sat, val);
    @(posedge clk);
  endtask

  task automatic send_tick();
    logic [15:0] hue;
    logic [15:0] sv;
    hue = $urandom;
    sv = $urandom;
    send_item(OP_TICK, hue, sv[7:0], sv[15:8]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_colors.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] step, input logic char_en,
                                input logic led_en);
    logic [1:0] idx_seq [4];
    logic [15:0] data_seq [4];
    logic [15:0] noise_a;
    logic [15:0] noise_b;
    logic [15:0] noise_c;
    noise_a = $urandom;
    noise_b = $urandom;
    noise_c = $urandom;
    idx_seq[0] = CFG_PHASE_STEP;
    idx_seq[1] = CFG_UNUSED;
    idx_seq[2] = CFG_CHAR_ENABLE;
    idx_seq[3] = CFG_LED_ENABLE;
    data_seq[0] = step;
    data_seq[1] = noise_a;
    data_seq[2] = {noise_b[15:1], char_en};
    data_seq[3] = {noise_c[15:1], led_en};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_seq[k];
      cfg_data <= data_seq[k];
      do @(negedge clk); while (!cfg_ready);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    model_step = step;
    model_char_en = char_en;
    model_led_en = led_en;
  endtask

  task automatic test_reset_defaults();
    send_tick();
    send_tick();
    send_item(OP_DIRECT, 16'sd0, 8'd255, 8'd255);
    wait_idle();
  endtask

  task automatic test_direct_conversion();
    int hues [16] = '{-32768, 32767, -1, 0, 30, 59, 60, 90, 150, 210, 270, 330, 359, 360,
                      -360, -361};
    int sats [16] = '{128, 255, 0, 255, 1, 200, 255, 90, 255, 64, 255, 180, 255, 255, 0, 33};
    int vals [16] = '{200, 255, 255, 0, 255, 128, 255, 77, 255, 255, 1, 200, 255, 150, 0, 240};
    for (int k = 0; k < 16; k++) begin
      send_item(OP_DIRECT, hues[k][15:0], sats[k][7:0], vals[k][7:0]);
    end
    wait_idle();
  endtask

  task automatic test_tick_enables();
    apply_settings(16'h0000, 1'b1, 1'b1);
    send_tick();
    wait_idle();
    apply_settings(16'hFFFF, 1'b1, 1'b0);
    send_tick();
    wait_idle();
    apply_settings(16'h0001, 1'b0, 1'b1);
    send_tick();
    wait_idle();
    // With both outputs off the phase still moves on.
    apply_settings(16'h8000, 1'b0, 1'b0);
    send_tick();
    send_tick();
    wait_idle();
    apply_settings(16'd365, 1'b1, 1'b1);
    send_tick();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int total);
    int sent;
    int burst;
    logic [15:0] step;
    logic [15:0] hue;
    logic [15:0] sv;
    logic char_en;
    logic led_en;
    sent = 0;
    while (sent < total) begin
      case ($urandom_range(0, 5))
        0: step = 16'h0000;
        1: step = 16'hFFFF;
        2: step = 16'h0001;
        3: step = 16'h8000;
        4: step = 16'd365;
        default: step = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: {char_en, led_en} = 2'b00;
        1: {char_en, led_en} = 2'b10;
        2: {char_en, led_en} = 2'b01;
        default: {char_en, led_en} = 2'b11;
      endcase
      apply_settings(step, char_en, led_en);
      idling_on = (total - sent > 120) && ($urandom_range(0, 3) != 0);
      burst = $urandom_range(15, 50);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 6) begin
          send_tick();
        end else begin
          if ($urandom_range(0, 1) == 0) begin
            hue = $urandom;
          end else begin
            hue = 16'($urandom_range(0, 1440) - 720);
          end
          sv = $urandom;
          if ($urandom_range(0, 7) == 0) begin
            sv[7:0] = 8'd0;
          end
          send_item(OP_DIRECT, hue, sv[7:0], sv[15:8]);
        end
        sent++;
      end
      wait_idle();
    end
  endtask

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        mismatches++;
        $display("%0t unexpected color: expected none, actual kind %0d index %0d", $time,
                 out_kind, out_index);
      end else begin
        want = expected_colors.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("index", want.index, out_index);
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_wave_lut();
    model_phase = '0;
    model_step = 16'd365;
    model_char_en = 1'b1;
    model_led_en = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_direct_conversion();
    test_tick_enables();
    test_random_traffic(475);
    idling_on = 1'b0;
    wait_idle();
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gcg_pkg.sv
hdl/glow_color_generator_top.sv
hdl/gcg_checker.sv
verif/tb.sv
